@@ hdl/websocket_frame_deframer_top_assert.svh @@
// ----------------------------------------------------------------------------
// WebSocket deframer assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define WSD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("websocket deframer check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define WSD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("websocket deframer check failed");

`endif

@@ hdl/wsd_pkg.sv @@
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Types and constants shared by the parser, the queue and the output stage.
// ----------------------------------------------------------------------------
package wsd_pkg;

    // Header decode constants.
    localparam logic [7:0] OPCODE_MASK    = 8'h0F;
    localparam logic [7:0] LEN7_MASK      = 8'h7F;
    localparam logic [7:0] TOP_BIT        = 8'h80;
    localparam logic [7:0] OPCODE_TEXT    = 8'h01;
    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

    // Queue between the parser and the output stage.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Parser phases.
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HDR2,
        PH_EXT,
        PH_MASK,
        PH_PAYLOAD,
        PH_DROP
    } t_phase;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_DATA    = 3'd0,
        ST_NOTTEXT = 3'd1,
        ST_NOTFIN  = 3'd2,
        ST_LEN64   = 3'd3,
        ST_EMPTY   = 3'd4
    } t_status;

    // One queued result: raw byte plus the key byte it is unmasked with.
    typedef struct packed {
        logic [7:0]  data;
        logic [7:0]  key;
        t_status     status;
        logic        last;
        logic [15:0] length;
    } t_cmd;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

@@ hdl/websocket_frame_deframer_top.sv @@
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Receive-side parser for text frames, one byte per item.
// ----------------------------------------------------------------------------
// The block takes one frame byte every clock cycle and gives at most one
// result per byte. Each byte is classified and its result written into the
// result queue at the accepting edge; the output register loads the queue
// head whenever it is empty or being taken. The four-entry result queue
// absorbs output stalls; the input stalls only while that queue is full.
// Final text frames are unmasked and passed on byte by byte, and an empty
// one gives a single empty status; other frames and 64-bit lengths give a
// single reject status and are dropped up to the next frame start.
module websocket_frame_deframer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_frame_start,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_payload_byte,
    output logic [2:0]  o_status,
    output logic        o_last_of_frame,
    output logic [15:0] o_frame_length
);
    import wsd_pkg::*;

    logic    w_push;
    logic    w_pop;
    t_cmd    w_cmd_in;
    t_cmd    w_cmd_out;
    t_q_stat w_q_stat;
    logic    w_out_status;
    logic    w_in_reject;

    // Parser front end.
    wsd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .i_byte   (i_in_byte),
        .i_start  (i_frame_start),
        .i_q_stat (w_q_stat),
        .o_stall  (o_in_stall),
        .o_push   (w_push),
        .o_cmd    (w_cmd_in)
    );

    // Result queue.
    wsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .i_pop   (w_pop),
        .o_cmd   (w_cmd_out),
        .o_stat  (w_q_stat)
    );

    // Output stage.
    wsd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_stat        (w_q_stat),
        .i_cmd           (w_cmd_out),
        .o_pop           (w_pop),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_payload_byte  (o_payload_byte),
        .o_status        (o_status),
        .o_last_of_frame (o_last_of_frame),
        .o_frame_length  (o_frame_length)
    );

    // Conditions watched by the checks below.
    assign w_out_status = o_out_valid && (o_status != 3'(ST_DATA));
    assign w_in_reject  = i_in_valid && !o_in_stall && i_frame_start &&
                          ((i_in_byte & OPCODE_MASK) != OPCODE_TEXT);

    // Checks on the internal handshakes and result encoding.
`include "websocket_frame_deframer_top_assert.svh"

    `WSD_ASSERT_IMP(a_no_push_when_full, w_push, !w_q_stat.full)
    `WSD_ASSERT_IMP(a_no_pop_when_empty, w_pop, !w_q_stat.empty)
    `WSD_ASSERT_IMP(a_status_is_last, w_out_status, o_last_of_frame && o_payload_byte == 8'd0)
    `WSD_ASSERT_NXT(a_reject_queued, w_in_reject, !w_q_stat.empty)

endmodule

@@ hdl/wsd_front.sv @@
// ----------------------------------------------------------------------------
// WebSocket deframer parser
// Accepts received bytes, tracks the header phase and queues one result
// for every payload byte, reject or empty frame.
// ----------------------------------------------------------------------------
module wsd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_byte,
    input  logic            i_start,
    input  wsd_pkg::t_q_stat i_q_stat,
    output logic            o_stall,
    output logic            o_push,
    output wsd_pkg::t_cmd   o_cmd
);
    import wsd_pkg::*;

    t_phase      r_phase,    n_phase;
    logic        r_mask_on,  n_mask_on;
    logic [31:0] r_key,      n_key;
    logic [1:0]  r_key_cnt,  n_key_cnt;
    logic        r_ext_cnt,  n_ext_cnt;
    logic [15:0] r_len,      n_len;
    logic [15:0] r_index,    n_index;

    logic        w_accept;
    logic [6:0]  w_len7;
    logic [15:0] w_ext_len;
    logic        w_last;
    logic [7:0]  w_key_byte;

    // An item is taken whenever the queue has room.
    assign o_stall  = i_q_stat.full;
    assign w_accept = i_valid && !i_q_stat.full;

    assign w_len7    = i_byte[6:0] & LEN7_MASK[6:0];
    assign w_ext_len = {r_len[7:0], i_byte};
    assign w_last    = ({1'b0, r_index} + 17'd1) >= {1'b0, r_len};

    // Key byte for the current payload position.
    always_comb begin
        case (r_index[1:0])
            2'd0:    w_key_byte = r_key[31:24];
            2'd1:    w_key_byte = r_key[23:16];
            2'd2:    w_key_byte = r_key[15:8];
            default: w_key_byte = r_key[7:0];
        endcase
    end

    // Next-state and header register updates.
    always_comb begin
        n_phase   = r_phase;
        n_mask_on = r_mask_on;
        n_key     = r_key;
        n_key_cnt = r_key_cnt;
        n_ext_cnt = r_ext_cnt;
        n_len     = r_len;
        n_index   = r_index;
        if (w_accept) begin
            if (i_start) begin
                n_mask_on = 1'b0;
                n_key     = '0;
                n_key_cnt = '0;
                n_ext_cnt = 1'b0;
                n_len     = '0;
                n_index   = '0;
                if ((i_byte & OPCODE_MASK) != OPCODE_TEXT) begin
                    n_phase = PH_DROP;
                end else if ((i_byte & TOP_BIT) != TOP_BIT) begin
                    n_phase = PH_DROP;
                end else begin
                    n_phase = PH_HDR2;
                end
            end else begin
                case (r_phase)
                    PH_HDR2: begin
                        n_mask_on = i_byte[7];
                        if (w_len7 == LEN_CODE_EXT64) begin
                            n_phase = PH_DROP;
                        end else if (w_len7 == LEN_CODE_EXT16) begin
                            n_ext_cnt = 1'b0;
                            n_len     = '0;
                            n_phase   = PH_EXT;
                        end else begin
                            n_len = {9'd0, w_len7};
                            if (i_byte[7]) begin
                                n_key_cnt = '0;
                                n_phase   = PH_MASK;
                            end else begin
                                n_index = '0;
                                n_phase = (w_len7 == 7'd0) ? PH_IDLE : PH_PAYLOAD;
                            end
                        end
                    end
                    PH_EXT: begin
                        n_len = w_ext_len;
                        if (!r_ext_cnt) begin
                            n_ext_cnt = 1'b1;
                        end else begin
                            n_ext_cnt = 1'b0;
                            if (r_mask_on) begin
                                n_key_cnt = '0;
                                n_phase   = PH_MASK;
                            end else begin
                                n_index = '0;
                                n_phase = (w_ext_len == 16'd0) ? PH_IDLE : PH_PAYLOAD;
                            end
                        end
                    end
                    PH_MASK: begin
                        n_key = {r_key[23:0], i_byte};
                        if (r_key_cnt != 2'd3) begin
                            n_key_cnt = r_key_cnt + 2'd1;
                        end else begin
                            n_key_cnt = '0;
                            n_index   = '0;
                            n_phase   = (r_len == 16'd0) ? PH_IDLE : PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD: begin
                        n_index = r_index + 16'd1;
                        if (w_last) begin
                            n_phase = PH_IDLE;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

    // Result classification for the queue.
    always_comb begin
        o_push = 1'b0;
        o_cmd  = '{data: '0, key: '0, status: ST_DATA, last: 1'b1, length: '0};
        if (w_accept) begin
            if (i_start) begin
                if ((i_byte & OPCODE_MASK) != OPCODE_TEXT) begin
                    o_push     = 1'b1;
                    o_cmd.status = ST_NOTTEXT;
                end else if ((i_byte & TOP_BIT) != TOP_BIT) begin
                    o_push     = 1'b1;
                    o_cmd.status = ST_NOTFIN;
                end
            end else begin
                case (r_phase)
                    PH_HDR2: begin
                        if (w_len7 == LEN_CODE_EXT64) begin
                            o_push       = 1'b1;
                            o_cmd.status = ST_LEN64;
                        end else if (w_len7 == 7'd0 && !i_byte[7]) begin
                            o_push       = 1'b1;
                            o_cmd.status = ST_EMPTY;
                        end
                    end
                    PH_EXT: begin
                        if (r_ext_cnt && !r_mask_on && w_ext_len == 16'd0) begin
                            o_push       = 1'b1;
                            o_cmd.status = ST_EMPTY;
                        end
                    end
                    PH_MASK: begin
                        if (r_key_cnt == 2'd3 && r_len == 16'd0) begin
                            o_push       = 1'b1;
                            o_cmd.status = ST_EMPTY;
                        end
                    end
                    PH_PAYLOAD: begin
                        o_push       = 1'b1;
                        o_cmd.status = ST_DATA;
                        o_cmd.data   = i_byte;
                        o_cmd.key    = r_mask_on ? w_key_byte : 8'd0;
                        o_cmd.last   = w_last;
                        o_cmd.length = r_len;
                    end
                    default: begin
                        o_push = 1'b0;
                    end
                endcase
            end
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_mask_on <= 1'b0;
            r_key     <= '0;
            r_key_cnt <= '0;
            r_ext_cnt <= 1'b0;
            r_len     <= '0;
            r_index   <= '0;
        end else begin
            r_phase   <= n_phase;
            r_mask_on <= n_mask_on;
            r_key     <= n_key;
            r_key_cnt <= n_key_cnt;
            r_ext_cnt <= n_ext_cnt;
            r_len     <= n_len;
            r_index   <= n_index;
        end
    end

endmodule

@@ hdl/wsd_queue.sv @@
// ----------------------------------------------------------------------------
// WebSocket deframer result queue
// Short first-in first-out buffer that decouples the parser from the
// output stage.
// ----------------------------------------------------------------------------
module wsd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  wsd_pkg::t_cmd    i_cmd,
    input  logic             i_pop,
    output wsd_pkg::t_cmd    o_cmd,
    output wsd_pkg::t_q_stat o_stat
);
    import wsd_pkg::*;

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CW-1:0] r_count,  n_count;

    // Head entry and fill status.
    assign o_cmd        = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);

    // Pointer and count updates.
    always_comb begin
        n_wr_ptr = i_push ? Q_AW'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = i_pop  ? Q_AW'(r_rd_ptr + 1'b1) : r_rd_ptr;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

@@ hdl/wsd_back.sv @@
// ----------------------------------------------------------------------------
// WebSocket deframer output stage
// Pops queued results, unmasks payload bytes and holds each result in an
// output register until it is taken.
// ----------------------------------------------------------------------------
module wsd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  wsd_pkg::t_q_stat i_q_stat,
    input  wsd_pkg::t_cmd    i_cmd,
    output logic             o_pop,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output logic [7:0]       o_payload_byte,
    output logic [2:0]       o_status,
    output logic             o_last_of_frame,
    output logic [15:0]      o_frame_length
);
    import wsd_pkg::*;

    logic        r_valid,  n_valid;
    logic [7:0]  r_byte;
    logic [2:0]  r_status;
    logic        r_last;
    logic [15:0] r_length;

    // Load a new result when the output register is empty or being taken.
    assign o_pop   = !i_q_stat.empty && (!r_valid || !i_out_stall);
    assign n_valid = o_pop ? 1'b1 : (r_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload registers; a byte is unmasked on its way in.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_byte   <= i_cmd.data ^ i_cmd.key;
            r_status <= 3'(i_cmd.status);
            r_last   <= i_cmd.last;
            r_length <= i_cmd.length;
        end
    end

    assign o_out_valid     = r_valid;
    assign o_payload_byte  = r_byte;
    assign o_status        = r_status;
    assign o_last_of_frame = r_last;
    assign o_frame_length  = r_length;

endmodule
